>>> hdl/rgb_conv3x3_zero_pad_clamp_unit_defines.svh
// Assertion macros for the 3x3 RGB convolution unit
`ifndef RGB_CONV3X3_ZERO_PAD_CLAMP_UNIT_DEFINES_SVH
`define RGB_CONV3X3_ZERO_PAD_CLAMP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rcc_pkg.sv
// Shared types, constants and defaults for the 3x3 RGB convolution unit
package rcc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int COEF_FRAC_DEF  = 12;

	localparam int DIM_REG_W  = 11;
	localparam int COEF_REG_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int WGT_W      = 16;
	localparam int CH_W       = 8;
	localparam int PROD_W     = CH_W + 1 + WGT_W;
	localparam int COL_SUM_W  = PROD_W + 2;
	localparam int ACC_W      = COL_SUM_W + 2;

	localparam logic [DIM_REG_W-1:0]  DIM_RESET       = 11'd1024;
	localparam logic [COEF_REG_W-1:0] COEF_SIDE_RESET = 48'h0;
	localparam logic [COEF_REG_W-1:0] COEF_MID_RESET  = 48'h0000_1000_0000;
	localparam logic [CH_W-1:0]       CH_MAX          = 8'd255;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH    = 3'd0,
		CFG_HEIGHT   = 3'd1,
		CFG_COEF_TOP = 3'd2,
		CFG_COEF_MID = 3'd3,
		CFG_COEF_BOT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	// one window column, index 0 is the upper row
	typedef pixel_t [2:0] col_t;

	typedef struct packed {
		logic            opcode;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            frame_end;
	} out_item_t;

	typedef struct packed {
		logic due;
		logic top_en;
		logic bot_en;
		logic left_en;
		logic right_en;
		logic last;
	} tap_ctl_t;

	typedef struct packed {
		logic shift;
		logic capture;
		logic top_en;
		logic bot_en;
		logic col_en;
	} cell_ctl_t;

endpackage

>>> hdl/rcc_stream_if.sv
// Valid/ready stream channel carrying one payload word
interface rcc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rcc_linebuf.sv
// Two line stores with read-first access and forwarding of the delayed upper write
module rcc_linebuf
	import rcc_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	input  pixel_t        pix,
	output pixel_t        up_s1,
	output pixel_t        mid_s1
);

	pixel_t        upper_mem [DEPTH];
	pixel_t        middle_mem [DEPTH];
	logic          upw_v_q;
	logic [AW-1:0] upw_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upw_v_q <= 1'b0;
		end else begin
			upw_v_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			upw_a_q <= addr;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_s1 <= middle_mem[addr];
			middle_mem[addr] <= pix;
		end
	end

	// the old middle entry moves up in the cycle after its read
	always_ff @(posedge clk) begin
		if (upw_v_q) begin
			upper_mem[upw_a_q] <= mid_s1;
		end
		if (rd_en) begin
			if (upw_v_q && (upw_a_q == addr)) begin
				up_s1 <= mid_s1;
			end else begin
				up_s1 <= upper_mem[addr];
			end
		end
	end

endmodule

>>> hdl/rcc_cell.sv
// Window column cell: holds one column, passes it left, forms its weighted column sums
module rcc_cell
	import rcc_pkg::*;
(
	input  logic                         clk,
	input  cell_ctl_t                    ctl,
	input  col_t                         col_in,
	input  logic [2:0][WGT_W-1:0]        wts,
	output col_t                         col_q,
	output logic [2:0][COL_SUM_W-1:0]    sum_s3
);

	logic [2:0][COL_SUM_W-1:0] sum_d;

	function automatic logic [CH_W-1:0] chan(pixel_t p, int ch);
		case (ch)
			0:       return p.red;
			1:       return p.green;
			default: return p.blue;
		endcase
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		logic signed [COL_SUM_W-1:0] acc;
		logic signed [PROD_W-1:0]    prod;
		logic                        row_on;
		for (int ch = 0; ch < 3; ch++) begin
			acc = '0;
			for (int r = 0; r < 3; r++) begin
				case (r)
					0:       row_on = ctl.top_en;
					2:       row_on = ctl.bot_en;
					default: row_on = 1'b1;
				endcase
				// select zero outright so masked taps never carry stale data
				if (row_on && ctl.col_en) begin
					prod = $signed({1'b0, chan(col_q[r], ch)}) * $signed(wts[r]);
				end else begin
					prod = '0;
				end
				acc = acc + prod;
			end
			sum_d[ch] = acc;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sum_s3 <= sum_d;
		end
	end

endmodule

>>> hdl/rgb_conv3x3_zero_pad_clamp_unit.sv
// Throughput: one item per cycle unless the result side stalls; a flush that steps two columns
// (single-row image) holds the input while the second column shifts in.
// Pipeline: line-store read, window cell shift, column sums, final add and clamp.
// Reset clears counters, pipeline valids and restores register defaults; the line stores
// are not cleared and need no clearing pass.
module rgb_conv3x3_zero_pad_clamp_unit
	import rcc_pkg::*;
#(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_REG_W-1:0] cfg_data,
	rcc_stream_if.sink            pixel,
	rcc_stream_if.source          result
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = HW + 2;
	localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(int'(CH_MAX) << COEF_FRAC_BITS);

	// configuration
	logic [DIM_REG_W-1:0]  width_q, height_q;
	logic [COEF_REG_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_RESET;
			height_q   <= DIM_RESET;
			coef_top_q <= COEF_SIDE_RESET;
			coef_mid_q <= COEF_MID_RESET;
			coef_bot_q <= COEF_SIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:    width_q    <= cfg_data[DIM_REG_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[DIM_REG_W-1:0];
				CFG_COEF_TOP: coef_top_q <= cfg_data;
				CFG_COEF_MID: coef_mid_q <= cfg_data;
				CFG_COEF_BOT: coef_bot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

	// front: position counters and the shift decision
	logic [COL_W-1:0] in_col_q, out_col_q, in_col_d, out_col_d;
	logic [ROW_W-1:0] in_row_q, out_row_q, in_row_d, out_row_d;
	logic             extra_q;
	logic             rdy1, rdy2, rdy3, rdy4, mv12;
	logic             take_in, is_flush, row_done, ignore, take, dbl, col_wrap, ocol_wrap;
	logic             last_pos;
	pixel_t           pix_in;
	tap_ctl_t         ctl_d;

	always_comb begin
		take_in  = pixel.valid && pixel.ready;
		is_flush = (pixel.data.opcode == OP_FLUSH);
		row_done = 32'(in_row_q) >= 32'(eff_h);
		ignore   = is_flush ? !row_done : row_done;
		take     = extra_q ? rdy1 : (take_in && !ignore);
		dbl      = !extra_q && is_flush && (in_row_q == ROW_W'(1)) && (in_col_q == '0);

		if (extra_q || is_flush) begin
			pix_in = '0;
		end else begin
			pix_in = '{blue: pixel.data.in_blue, green: pixel.data.in_green,
				red: pixel.data.in_red};
		end

		col_wrap = (32'(in_col_q) + 32'd1) >= 32'(eff_w);
		in_col_d = col_wrap ? '0 : in_col_q + 1'b1;
		in_row_d = (col_wrap && (in_row_q != '1)) ? in_row_q + 1'b1 : in_row_q;

		last_pos = ((32'(out_row_q) + 32'd1) >= 32'(eff_h)) &&
			((32'(out_col_q) + 32'd1) >= 32'(eff_w));
		ocol_wrap = (32'(out_col_q) + 32'd1) >= 32'(eff_w);
		out_col_d = ocol_wrap ? '0 : out_col_q + 1'b1;
		out_row_d = (ocol_wrap && (out_row_q != '1)) ? out_row_q + 1'b1 : out_row_q;

		ctl_d.due      = (in_row_q >= ROW_W'(2)) ||
			((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		ctl_d.top_en   = (out_row_q != '0);
		ctl_d.bot_en   = (32'(out_row_q) + 32'd1) < 32'(eff_h);
		ctl_d.left_en  = (out_col_q != '0);
		ctl_d.right_en = (32'(out_col_q) + 32'd1) < 32'(eff_w);
		ctl_d.last     = ctl_d.due && last_pos;
	end

	assign pixel.ready = rdy1 && !extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			extra_q   <= 1'b0;
		end else begin
			if (extra_q) begin
				extra_q <= !rdy1;
			end else if (take && dbl) begin
				extra_q <= 1'b1;
			end
			if (take) begin
				if (ctl_d.last) begin
					// frame complete: start over
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					in_col_q <= in_col_d;
					in_row_q <= in_row_d;
					if (ctl_d.due) begin
						out_col_q <= out_col_d;
						out_row_q <= out_row_d;
					end
				end
			end
		end
	end

	// pipeline flow
	logic      s1_v_q, s2_v_q, s3_v_q, out_v_q;
	tap_ctl_t  ctl_s1, ctl_s2;
	logic      last_s3;
	pixel_t    pix_s1, up_s1, mid_s1;
	out_item_t out_q;

	assign rdy4 = !out_v_q || result.ready;
	assign rdy3 = !s3_v_q || rdy4;
	assign rdy2 = !s2_v_q || rdy3;
	assign rdy1 = !s1_v_q || rdy2;
	assign mv12 = s1_v_q && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1) begin
				s1_v_q <= take;
			end
			if (rdy2) begin
				s2_v_q <= mv12 && ctl_s1.due;
			end
			if (rdy3) begin
				s3_v_q <= s2_v_q;
			end
			if (rdy4) begin
				out_v_q <= s3_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1 <= ctl_d;
			pix_s1 <= pix_in;
		end
		if (mv12) begin
			ctl_s2 <= ctl_s1;
		end
		if (rdy3 && s2_v_q) begin
			last_s3 <= ctl_s2.last;
		end
	end

	rcc_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (take),
		.addr   (in_col_q),
		.pix    (pix_in),
		.up_s1  (up_s1),
		.mid_s1 (mid_s1)
	);

	// window: three cells, new column enters on the right and moves left
	col_t                      col_q   [3];
	col_t                      col_feed[3];
	cell_ctl_t                 cell_ctl[3];
	logic [2:0][WGT_W-1:0]     cell_wts[3];
	logic [2:0][COL_SUM_W-1:0] sum_s3  [3];

	for (genvar c = 0; c < 3; c++) begin : g_cell
		if (c == 2) begin : g_feed_new
			assign col_feed[c] = {pix_s1, mid_s1, up_s1};
		end else begin : g_feed_next
			assign col_feed[c] = col_q[c+1];
		end

		assign cell_wts[c] = {coef_bot_q[c*WGT_W +: WGT_W], coef_mid_q[c*WGT_W +: WGT_W],
			coef_top_q[c*WGT_W +: WGT_W]};

		always_comb begin
			cell_ctl[c].shift   = mv12;
			cell_ctl[c].capture = rdy3 && s2_v_q;
			cell_ctl[c].top_en  = ctl_s2.top_en;
			cell_ctl[c].bot_en  = ctl_s2.bot_en;
			case (c)
				0:       cell_ctl[c].col_en = ctl_s2.left_en;
				2:       cell_ctl[c].col_en = ctl_s2.right_en;
				default: cell_ctl[c].col_en = 1'b1;
			endcase
		end

		rcc_cell u_cell (
			.clk    (clk),
			.ctl    (cell_ctl[c]),
			.col_in (col_feed[c]),
			.wts    (cell_wts[c]),
			.col_q  (col_q[c]),
			.sum_s3 (sum_s3[c])
		);
	end

	// final add across columns, clamp, drop the fraction
	logic [2:0][CH_W-1:0] ch_d;

	always_comb begin
		logic signed [ACC_W-1:0]     acc;
		logic signed [COL_SUM_W-1:0] part;
		for (int ch = 0; ch < 3; ch++) begin
			acc = '0;
			for (int c = 0; c < 3; c++) begin
				part = sum_s3[c][ch];
				acc  = acc + part;
			end
			if (acc[ACC_W-1]) begin
				ch_d[ch] = '0;
			end else if (acc >= CLAMP_HI) begin
				ch_d[ch] = CH_MAX;
			end else begin
				ch_d[ch] = acc[COEF_FRAC_BITS +: CH_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && s3_v_q) begin
			out_q.out_red   <= ch_d[0];
			out_q.out_green <= ch_d[1];
			out_q.out_blue  <= ch_d[2];
			out_q.frame_end <= last_s3;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	`include "rgb_conv3x3_zero_pad_clamp_unit_defines.svh"

	`RCC_ASSERT_NOW(a_extra_blocks_input, extra_q, !pixel.ready, "input taken during second flush step")
	`RCC_ASSERT_NOW(a_extra_gives_result, extra_q && take, ctl_d.due, "second flush step gave no result")
	`RCC_ASSERT_NEXT(a_frame_restart, take && ctl_d.last, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "counters not cleared after frame end")

endmodule
